FILE: rtl/bge_pkg.sv
// shared types and codes for the button gesture event block
package bge_pkg;

  // event codes as reported on event_code
  localparam logic [2:0] EV_PRESS   = 3'd0;
  localparam logic [2:0] EV_RELEASE = 3'd1;
  localparam logic [2:0] EV_CLICK   = 3'd2;
  localparam logic [2:0] EV_DOUBLE  = 3'd3;
  localparam logic [2:0] EV_MULTI   = 3'd4;
  localparam logic [2:0] EV_LSTART  = 3'd5;
  localparam logic [2:0] EV_HOLD    = 3'd6;
  localparam logic [2:0] EV_LEND    = 3'd7;

  // configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd1;
  localparam logic [2:0] REG_HOLD_REPEAT  = 3'd2;
  localparam logic [2:0] REG_CLICK_WINDOW = 3'd3;
  localparam logic [2:0] REG_EVENT_MASK   = 3'd4;
  localparam logic [2:0] REG_PRESSED_LVL  = 3'd5;
  localparam logic [2:0] REG_CLICK_LIMIT  = 3'd6;

  localparam int unsigned ElapsedW = 17;
  localparam logic [ElapsedW-1:0] ElapsedMax = '1;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [15:0] long_press_time;
    logic [15:0] hold_repeat_time;
    logic [15:0] click_window_time;
    logic [7:0]  event_enable_mask;
    logic        pressed_level;
    logic [7:0]  click_limit;
  } cfg_t;

  typedef struct packed {
    logic       event_valid;
    logic [2:0] event_code;
    logic [7:0] event_clicks;
    logic       is_down;
  } result_t;

endpackage

FILE: rtl/bge_cfg.sv
// configuration register file of the button gesture event block
module bge_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [2:0]         wr_index_i,
  input  logic [15:0]        wr_data_i,
  output bge_pkg::cfg_t      cfg_o
);

  bge_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        bge_pkg::REG_DEBOUNCE:     cfg_d.debounce_time     = wr_data_i;
        bge_pkg::REG_LONG_PRESS:   cfg_d.long_press_time   = wr_data_i;
        bge_pkg::REG_HOLD_REPEAT:  cfg_d.hold_repeat_time  = wr_data_i;
        bge_pkg::REG_CLICK_WINDOW: cfg_d.click_window_time = wr_data_i;
        bge_pkg::REG_EVENT_MASK:   cfg_d.event_enable_mask = wr_data_i[7:0];
        bge_pkg::REG_PRESSED_LVL:  cfg_d.pressed_level     = wr_data_i[0];
        bge_pkg::REG_CLICK_LIMIT:  cfg_d.click_limit       = wr_data_i[7:0];
        default: ; // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time     <= 16'd20;
      cfg_q.long_press_time   <= 16'd1000;
      cfg_q.hold_repeat_time  <= 16'd100;
      cfg_q.click_window_time <= 16'd300;
      cfg_q.event_enable_mask <= 8'hFF;
      cfg_q.pressed_level     <= 1'b0;
      cfg_q.click_limit       <= 8'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/bge_fsm.sv
// gesture state machine with the result register
module bge_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               level_i,
  input  logic [15:0]        ms_i,
  input  bge_pkg::cfg_t      cfg_i,
  output bge_pkg::result_t   result_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEB_PRESS,
    ST_PRESSED,
    ST_DEB_RELEASE,
    ST_WAIT_CLICK,
    ST_LONG
  } state_e;

  state_e                          state_q, state_d;
  logic [bge_pkg::ElapsedW-1:0]    elapsed_q, elapsed_d;
  logic [7:0]                      tally_q, tally_d;
  logic                            down_q, down_d;
  logic                            after_long_q, after_long_d;
  logic                            skip_q, skip_d;
  bge_pkg::result_t                result_q, result_d;

  logic                            active;
  logic [bge_pkg::ElapsedW:0]      sum;
  logic [bge_pkg::ElapsedW-1:0]    adv;
  logic                            fire;
  logic [2:0]                      fire_code;
  logic [7:0]                      fire_clicks;

  assign active = (level_i == cfg_i.pressed_level);
  assign sum    = {1'b0, elapsed_q} + {2'b00, ms_i};
  assign adv    = sum[bge_pkg::ElapsedW] ? bge_pkg::ElapsedMax
                                         : sum[bge_pkg::ElapsedW-1:0];

  always_comb begin
    state_d      = state_q;
    elapsed_d    = elapsed_q;
    tally_d      = tally_q;
    down_d       = down_q;
    after_long_d = after_long_q;
    skip_d       = skip_q;
    fire         = 1'b0;
    fire_code    = bge_pkg::EV_PRESS;
    fire_clicks  = 8'd0;

    if (skip_q) begin
      skip_d = active;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (active) begin
            elapsed_d = '0;
            state_d   = ST_DEB_PRESS;
          end
        end
        ST_DEB_PRESS: begin
          if (!active) begin
            elapsed_d = '0;
            state_d   = (tally_q == 8'd0) ? ST_IDLE : ST_WAIT_CLICK;
          end else if (adv >= {1'b0, cfg_i.debounce_time}) begin
            down_d      = 1'b1;
            elapsed_d   = '0;
            state_d     = ST_PRESSED;
            fire        = 1'b1;
            fire_code   = bge_pkg::EV_PRESS;
            fire_clicks = tally_q;
          end else begin
            elapsed_d = adv;
          end
        end
        ST_DEB_RELEASE: begin
          if (active) begin
            elapsed_d = '0;
            state_d   = after_long_q ? ST_LONG : ST_PRESSED;
          end else if (adv >= {1'b0, cfg_i.debounce_time}) begin
            down_d    = 1'b0;
            elapsed_d = '0;
            fire      = 1'b1;
            if (after_long_q) begin
              after_long_d = 1'b0;
              state_d      = ST_IDLE;
              fire_code    = bge_pkg::EV_LEND;
              fire_clicks  = tally_q;
            end else begin
              if (tally_q < cfg_i.click_limit) begin
                tally_d = tally_q + 8'd1;
              end
              state_d     = ST_WAIT_CLICK;
              fire_code   = bge_pkg::EV_RELEASE;
              fire_clicks = tally_d;
            end
          end else begin
            elapsed_d = adv;
          end
        end
        ST_PRESSED: begin
          if (!active) begin
            elapsed_d    = '0;
            after_long_d = 1'b0;
            state_d      = ST_DEB_RELEASE;
          end else if (adv >= {1'b0, cfg_i.long_press_time}) begin
            tally_d     = 8'd0;
            elapsed_d   = '0;
            state_d     = ST_LONG;
            fire        = 1'b1;
            fire_code   = bge_pkg::EV_LSTART;
            fire_clicks = 8'd0;
          end else begin
            elapsed_d = adv;
          end
        end
        ST_WAIT_CLICK: begin
          if (active) begin
            elapsed_d = '0;
            state_d   = ST_DEB_PRESS;
          end else if (adv >= {1'b0, cfg_i.click_window_time}) begin
            fire_clicks = tally_q;
            if (tally_q == 8'd1) begin
              fire      = 1'b1;
              fire_code = bge_pkg::EV_CLICK;
            end else if (tally_q == 8'd2) begin
              fire      = 1'b1;
              fire_code = bge_pkg::EV_DOUBLE;
            end else if (tally_q > 8'd2) begin
              fire      = 1'b1;
              fire_code = bge_pkg::EV_MULTI;
            end
            tally_d   = 8'd0;
            elapsed_d = '0;
            state_d   = ST_IDLE;
          end else begin
            elapsed_d = adv;
          end
        end
        ST_LONG: begin
          if (!active) begin
            elapsed_d    = '0;
            after_long_d = 1'b1;
            state_d      = ST_DEB_RELEASE;
          end else if (adv >= {1'b0, cfg_i.hold_repeat_time}) begin
            elapsed_d   = '0;
            fire        = 1'b1;
            fire_code   = bge_pkg::EV_HOLD;
            fire_clicks = tally_q;
          end else begin
            elapsed_d = adv;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end

    // masked events report zero valid, code and clicks
    result_d.event_valid  = fire && cfg_i.event_enable_mask[fire_code];
    result_d.event_code   = result_d.event_valid ? fire_code : 3'd0;
    result_d.event_clicks = result_d.event_valid ? fire_clicks : 8'd0;
    result_d.is_down      = down_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      elapsed_q    <= '0;
      tally_q      <= 8'd0;
      down_q       <= 1'b0;
      after_long_q <= 1'b0;
      skip_q       <= 1'b1;
      result_q     <= '0;
    end else if (step_i) begin
      state_q      <= state_d;
      elapsed_q    <= elapsed_d;
      tally_q      <= tally_d;
      down_q       <= down_d;
      after_long_q <= after_long_d;
      skip_q       <= skip_d;
      result_q     <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

FILE: rtl/button_gesture_event_fsm_top.sv
// top level of the button gesture event block: handshake, input register, assertions
//
// Debounces a sampled button level and turns it into gesture events (press, release,
// click, double, multi click, long-press start, hold repeat, long-press end), one result
// word per tick word. Throughput is one tick word per clock cycle while the result side
// takes its words. An accepted tick word waits in the input register; when it moves on,
// the state machine updates its state and loads the result register, which offers the
// result word. A stall on the result side backs up through the input register; the
// input side keeps taking words as long as the input register is empty or its word moves
// on, which needs the result register to be empty or being taken. The config port
// is always ready and should only be written while no tick is in flight. After reset the
// block ignores a button that is already held until it is first released.
module button_gesture_event_fsm_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        raw_level_i,
  input  logic [15:0] tick_ms_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        event_valid_o,
  output logic [2:0]  event_code_o,
  output logic [7:0]  event_clicks_o,
  output logic        is_down_o,
  // config writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  bge_pkg::cfg_t    cfg;
  bge_pkg::result_t result;

  // input register stage
  logic        in_valid_q, in_valid_d;
  logic        raw_level_q;
  logic [15:0] tick_ms_q;
  logic        out_valid_q, out_valid_d;

  logic in_accept;
  logic out_accept;
  logic step;

  assign cfg_ready_o = 1'b1;

  // the stored word moves on when the result register is free or being emptied
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_accept = out_valid_q && out_ready_i;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_accept) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raw_level_q <= raw_level_i;
      tick_ms_q   <= tick_ms_i;
    end
  end

  bge_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  bge_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .level_i  (raw_level_q),
    .ms_i     (tick_ms_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign out_valid_o    = out_valid_q;
  assign event_valid_o  = result.event_valid;
  assign event_code_o   = result.event_code;
  assign event_clicks_o = result.event_clicks;
  assign is_down_o      = result.is_down;

  // input side only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled result");

  // a reported event is always one that the mask enables
  a_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_valid_o) |-> cfg.event_enable_mask[event_code_o])
    else $error("masked event reported");

  // press leaves the button down, release and long end leave it up
  a_down_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_valid_o && event_code_o == bge_pkg::EV_PRESS) |-> is_down_o)
    else $error("press reported with button up");

  a_down_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_valid_o &&
     (event_code_o == bge_pkg::EV_RELEASE || event_code_o == bge_pkg::EV_LEND))
    |-> !is_down_o)
    else $error("release reported with button down");

  // no event means zero code and zero clicks
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !event_valid_o) |-> (event_code_o == 3'd0 && event_clicks_o == 8'd0))
    else $error("idle result carries nonzero event fields");

endmodule

FILE: tb/sv/bge_tb_pkg.sv
// gesture predictor and result scoreboard for the button gesture event testbench
`timescale 1ns / 100ps
package bge_tb_pkg;
  import bge_pkg::*;

  // index past the end of the register list, writes to it are dropped
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef enum logic [2:0] {
    G_IDLE,
    G_DEB_PRESS,
    G_PRESSED,
    G_DEB_RELEASE,
    G_WAIT_CLICK,
    G_LONG
  } gesture_state_e;

  class gesture_scoreboard;
    cfg_t                cfg;
    gesture_state_e      state;
    logic [ElapsedW-1:0] elapsed;
    logic [7:0]          clicks;
    logic                down;
    logic                long_release;
    logic                skip_held;
    result_t             word;
    result_t             pending_events[$];
    int unsigned         mismatches;

    function new();
      cfg = '{debounce_time: 16'd20, long_press_time: 16'd1000, hold_repeat_time: 16'd100,
              click_window_time: 16'd300, event_enable_mask: 8'hFF, pressed_level: 1'b0,
              click_limit: 8'd10};
      state = G_IDLE;
      elapsed = '0;
      clicks = '0;
      down = 1'b0;
      long_release = 1'b0;
      skip_held = 1'b1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_DEBOUNCE:     cfg.debounce_time = data;
        REG_LONG_PRESS:   cfg.long_press_time = data;
        REG_HOLD_REPEAT:  cfg.hold_repeat_time = data;
        REG_CLICK_WINDOW: cfg.click_window_time = data;
        REG_EVENT_MASK:   cfg.event_enable_mask = data[7:0];
        REG_PRESSED_LVL:  cfg.pressed_level = data[0];
        REG_CLICK_LIMIT:  cfg.click_limit = data[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return pending_events.size();
    endfunction

    // elapsed time saturates instead of wrapping
    function void add_time(logic [15:0] ms);
      logic [ElapsedW:0] sum;
      sum = elapsed + ms;
      elapsed = (sum > ElapsedMax) ? ElapsedMax : sum[ElapsedW-1:0];
    endfunction

    function void fire(logic [2:0] code);
      if (cfg.event_enable_mask[code]) begin
        word.event_valid = 1'b1;
        word.event_code = code;
        word.event_clicks = clicks;
      end
    endfunction

    function void note_tick(logic lvl, logic [15:0] ms);
      logic active;
      active = (lvl == cfg.pressed_level);
      word = '0;
      if (skip_held) begin
        skip_held = active;
      end else begin
        case (state)
          G_IDLE: begin
            if (active) begin
              elapsed = '0;
              state = G_DEB_PRESS;
            end
          end
          G_DEB_PRESS: begin
            if (!active) begin
              elapsed = '0;
              if (clicks == 0) state = G_IDLE;
              else state = G_WAIT_CLICK;
            end else begin
              add_time(ms);
              if (elapsed >= cfg.debounce_time) begin
                down = 1'b1;
                elapsed = '0;
                state = G_PRESSED;
                fire(EV_PRESS);
              end
            end
          end
          G_DEB_RELEASE: begin
            if (active) begin
              elapsed = '0;
              if (long_release) state = G_LONG;
              else state = G_PRESSED;
            end else begin
              add_time(ms);
              if (elapsed >= cfg.debounce_time) begin
                down = 1'b0;
                elapsed = '0;
                if (long_release) begin
                  long_release = 1'b0;
                  state = G_IDLE;
                  fire(EV_LEND);
                end else begin
                  if (clicks < cfg.click_limit) clicks++;
                  state = G_WAIT_CLICK;
                  fire(EV_RELEASE);
                end
              end
            end
          end
          G_PRESSED: begin
            if (!active) begin
              elapsed = '0;
              long_release = 1'b0;
              state = G_DEB_RELEASE;
            end else begin
              add_time(ms);
              if (elapsed >= cfg.long_press_time) begin
                clicks = '0;
                elapsed = '0;
                state = G_LONG;
                fire(EV_LSTART);
              end
            end
          end
          G_WAIT_CLICK: begin
            if (active) begin
              elapsed = '0;
              state = G_DEB_PRESS;
            end else begin
              add_time(ms);
              if (elapsed >= cfg.click_window_time) begin
                if (clicks == 1) fire(EV_CLICK);
                else if (clicks == 2) fire(EV_DOUBLE);
                else if (clicks > 2) fire(EV_MULTI);
                clicks = '0;
                elapsed = '0;
                state = G_IDLE;
              end
            end
          end
          default: begin
            if (!active) begin
              elapsed = '0;
              long_release = 1'b1;
              state = G_DEB_RELEASE;
            end else begin
              add_time(ms);
              if (elapsed >= cfg.hold_repeat_time) begin
                elapsed = '0;
                fire(EV_HOLD);
              end
            end
          end
        endcase
      end
      word.is_down = down;
      pending_events.push_back(word);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(logic ev_valid, logic [2:0] code, logic [7:0] n_clicks,
                             logic is_down);
      result_t want;
      if (pending_events.size() == 0) begin
        $error("result word with no tick outstanding");
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_valid", want.event_valid, ev_valid);
        check_field("event_code", want.event_code, code);
        check_field("event_clicks", want.event_clicks, n_clicks);
        check_field("is_down", want.is_down, is_down);
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/button_gesture_event_fsm_top_test.sv
// testbench top for the button gesture event block: tick stimulus, idling, result checks
`timescale 1ns / 100ps
module button_gesture_event_fsm_top_test;
  import bge_pkg::*;
  import bge_tb_pkg::*;

  typedef enum int unsigned {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        raw_level_i = 1'b0;
  logic [15:0] tick_ms_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        event_valid_o;
  logic [2:0]  event_code_o;
  logic [7:0]  event_clicks_o;
  logic        is_down_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = REG_DEBOUNCE;
  logic [15:0] cfg_data_i = '0;

  gesture_scoreboard gestures;

  // settings the stimulus is currently shaped for
  cfg_t        cur;
  int unsigned ms_step = 10;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned ticks_sent = 0;

  // long receiver hold-off: main flow bumps the ask, the receiver owns the count
  int unsigned rx_hold_ask = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;

  // opening ticks under reset settings ({level, ms}, level 0 means pressed):
  // held at start and skipped, zero and full-scale ms, press, long start,
  // hold repeat, bounce back into long press, long end, then a double click
  logic [16:0] opening_ticks [25] = '{
    {1'b0, 16'd0}, {1'b0, 16'd65535}, {1'b1, 16'd1}, {1'b0, 16'd0}, {1'b0, 16'd65535},
    {1'b0, 16'd65535}, {1'b0, 16'd50}, {1'b0, 16'd50}, {1'b1, 16'd5}, {1'b0, 16'd1},
    {1'b1, 16'd1}, {1'b1, 16'd30}, {1'b0, 16'd1}, {1'b0, 16'd20}, {1'b1, 16'd1},
    {1'b1, 16'd20}, {1'b0, 16'd1}, {1'b0, 16'd25}, {1'b1, 16'd1}, {1'b1, 16'd25},
    {1'b1, 16'd300}, {1'b0, 16'd1}, {1'b0, 16'd20}, {1'b1, 16'd1}, {1'b1, 16'd20}
  };

  button_gesture_event_fsm_top dut (.*);

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver side: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold_ask != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_ask;
      rx_hold_left <= 60;
      out_ready_i <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // everything is observed on the rising edge: config writes and tick words
  // feed the predictor, result words are checked against it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) gestures.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) gestures.note_tick(raw_level_i, tick_ms_i);
      if (out_valid_o && out_ready_i)
        gestures.check_word(event_valid_o, event_code_o, event_clicks_o, is_down_o);
    end
  end

  function automatic void set_idling(idle_mode_e mode);
    case (mode)
      IDLE_SENDER: begin
        tx_idle_pct = 57;
        rx_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        tx_idle_pct = 0;
        rx_stall_pct = 57;
      end
      IDLE_BOTH: begin
        tx_idle_pct = 6;
        rx_stall_pct = 6;
      end
      default: begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
    endcase
  endfunction

  // mostly steps small against the thresholds, now and then zero or full scale
  function automatic logic [15:0] pick_ms();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return 16'($urandom_range(65535));
    return 16'($urandom_range(1, ms_step));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance;
  // valid stays high unless the sender idles before the next word
  task automatic send_tick(input logic lvl, input logic [15:0] ms);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_level_i <= lvl;
    tick_ms_i <= ms;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  // hold down or up for span_ms or at most 48 ticks, with the odd contact bounce
  task automatic hold_for(input logic pressed, input int unsigned span_ms);
    int unsigned sum;
    int unsigned n;
    logic        lvl;
    logic [15:0] ms;
    sum = 0;
    n = 0;
    do begin
      lvl = pressed ? cur.pressed_level : ~cur.pressed_level;
      if ($urandom_range(11) == 0) lvl = ~lvl;
      ms = pick_ms();
      send_tick(lvl, ms);
      sum += ms;
      n++;
    end while (sum < span_ms && n < 48);
  endtask

  task automatic run_gesture();
    int unsigned deb;
    int unsigned lng;
    int unsigned rep;
    int unsigned win;
    int unsigned n;
    deb = cur.debounce_time;
    lng = cur.long_press_time;
    rep = cur.hold_repeat_time;
    win = cur.click_window_time;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        // click train, sometimes long enough to hit the click limit
        n = ($urandom_range(3) == 0) ? $urandom_range(3, 12) : $urandom_range(1, 3);
        repeat (n) begin
          hold_for(1'b1, deb + $urandom_range(lng / 2));
          hold_for(1'b0, deb + $urandom_range(win / 2));
        end
        // usually let the click window run out, else leave the count pending
        if ($urandom_range(4) != 0) hold_for(1'b0, win + 1);
      end
      5, 6: begin
        // long press with hold repeats, then release
        hold_for(1'b1, deb + lng + $urandom_range(4 * rep));
        hold_for(1'b0, deb + win + 1);
      end
      7: begin
        // short glitches around the debounce time
        repeat ($urandom_range(1, 4)) begin
          hold_for(1'b1, $urandom_range(deb));
          hold_for(1'b0, $urandom_range(deb));
        end
      end
      default: begin
        repeat ($urandom_range(1, 8))
          send_tick(1'($urandom_range(1)), 16'($urandom_range(65535)));
      end
    endcase
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned start;
    start = ticks_sent;
    while (ticks_sent - start < n) run_gesture();
  endtask

  // config word, valid left high for a following write
  task automatic put_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drain the block, then rewrite every register; unused bits get junk
  task automatic load_settings(input cfg_t c, input int unsigned step);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (gestures.outstanding() != 0);
    repeat (4) @(negedge clk_i);
    put_reg(REG_DEBOUNCE, c.debounce_time);
    put_reg(REG_LONG_PRESS, c.long_press_time);
    put_reg(REG_HOLD_REPEAT, c.hold_repeat_time);
    put_reg(REG_CLICK_WINDOW, c.click_window_time);
    put_reg(REG_EVENT_MASK, {8'($urandom), c.event_enable_mask});
    put_reg(REG_PRESSED_LVL, {15'($urandom), c.pressed_level});
    put_reg(REG_CLICK_LIMIT, {8'($urandom), c.click_limit});
    put_reg(REG_UNUSED, 16'($urandom));
    cfg_valid_i <= 1'b0;
    cur = c;
    ms_step = step;
  endtask

  function automatic cfg_t moderate_settings(input int unsigned limit_hi);
    cfg_t c;
    c.debounce_time = 16'($urandom_range(2, 10));
    c.long_press_time = 16'($urandom_range(30, 90));
    c.hold_repeat_time = 16'($urandom_range(4, 20));
    c.click_window_time = 16'($urandom_range(12, 40));
    c.event_enable_mask = 8'($urandom_range(255));
    c.pressed_level = 1'($urandom_range(1));
    c.click_limit = 8'($urandom_range(1, limit_hi));
    return c;
  endfunction

  initial begin
    cfg_t c;
    gestures = new();
    cur = gestures.cfg;
    set_idling(IDLE_NONE);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed opening under reset settings
    foreach (opening_ticks[i]) send_tick(opening_ticks[i][16], opening_ticks[i][15:0]);

    // brisk timing, all events enabled, active-high button; receiver holds off
    // early on so the block backs up into the tick side
    c = '{debounce_time: 16'd4, long_press_time: 16'd40, hold_repeat_time: 16'd10,
          click_window_time: 16'd24, event_enable_mask: 8'hFF, pressed_level: 1'b1,
          click_limit: 8'd10};
    load_settings(c, 3);
    rx_hold_ask++;
    random_phase(160);

    // random moderate timing with a low click limit
    c = moderate_settings(4);
    load_settings(c, c.debounce_time / 2 + 1);
    set_idling(IDLE_SENDER);
    random_phase(160);

    // zero thresholds fire on the first check, zero limit never counts
    c = '{debounce_time: 16'd0, long_press_time: 16'd0, hold_repeat_time: 16'd0,
          click_window_time: 16'd0, event_enable_mask: 8'hFF, pressed_level: 1'b0,
          click_limit: 8'd0};
    load_settings(c, 2);
    set_idling(IDLE_RECEIVER);
    random_phase(120);

    // full-scale thresholds and click limit, coarse tick steps
    c = '{debounce_time: 16'hFFFF, long_press_time: 16'hFFFF, hold_repeat_time: 16'hFFFF,
          click_window_time: 16'hFFFF, event_enable_mask: 8'($urandom_range(255)),
          pressed_level: 1'b1, click_limit: 8'd255};
    load_settings(c, 24000);
    set_idling(IDLE_BOTH);
    random_phase(120);

    // every event masked off, limit of one
    c = '{debounce_time: 16'd1, long_press_time: 16'd30, hold_repeat_time: 16'd1,
          click_window_time: 16'd15, event_enable_mask: 8'h00, pressed_level: 1'b0,
          click_limit: 8'd1};
    load_settings(c, 2);
    set_idling(IDLE_NONE);
    random_phase(60);

    // random moderate timing again; a leftover count may now sit above the limit
    c = moderate_settings(12);
    load_settings(c, c.debounce_time / 2 + 1);
    set_idling(IDLE_BOTH);
    random_phase(250);

    in_valid_i <= 1'b0;
    while (gestures.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (gestures.mismatches == 0) begin
      $display("button_gesture_event_fsm_top_test passed");
    end else begin
      $display("button_gesture_event_fsm_top_test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("button_gesture_event_fsm_top_test failed");
    $finish;
  end

endmodule

FILE: button_gesture_event_fsm_top.f
rtl/bge_pkg.sv
rtl/bge_cfg.sv
rtl/bge_fsm.sv
rtl/button_gesture_event_fsm_top.sv
tb/sv/bge_tb_pkg.sv
tb/sv/button_gesture_event_fsm_top_test.sv
